// ----- sv/tfr_pkg.sv -----
// Package with the shared types and constants of the triangle fill rasterizer.
`default_nettype none

package tfr_pkg;

    localparam int XW          = 7;
    localparam int YW          = 6;
    localparam int DIFF_W      = 8;
    localparam int EDGE_W      = 16;
    localparam int SUM_W       = 17;
    localparam int MASK_W      = 128;
    localparam int HALF_W      = 64;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 136;
    localparam int STEP_W      = 3;

    localparam logic [STEP_W-1:0] MS_AB_Y    = 3'd0;
    localparam logic [STEP_W-1:0] MS_AB_X    = 3'd1;
    localparam logic [STEP_W-1:0] MS_BC_Y    = 3'd2;
    localparam logic [STEP_W-1:0] MS_BC_X    = 3'd3;
    localparam logic [STEP_W-1:0] MS_CA_Y    = 3'd4;
    localparam logic [STEP_W-1:0] MS_CA_X    = 3'd5;
    localparam logic [STEP_W-1:0] MS_WHOLE_Y = 3'd6;
    localparam logic [STEP_W-1:0] MS_WHOLE_X = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOX,
        ST_MUL,
        ST_DRAIN,
        ST_AREA,
        ST_SCAN,
        ST_ROW
    } t_state;

    typedef struct packed {
        logic              load;
        logic              box;
        logic              mul;
        logic [STEP_W-1:0] mul_step;
        logic              area;
        logic              pixel;
        logic              row_out;
    } t_cmd;

    typedef struct packed {
        logic box_empty;
        logic row_end;
        logic last_row;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

// ----- sv/tfr_ctrl.sv -----
// Sequencer of the triangle fill rasterizer: setup, pixel scan and row hand-off.
`default_nettype none

module tfr_ctrl
    import tfr_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  wire     i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_step       = r_step;
        o_in_ready   = 1'b0;
        o_cmd        = '0;
        o_cmd.mul_step = r_step;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_BOX;
                end
            end
            ST_BOX: begin
                o_cmd.box = 1'b1;
                n_step    = MS_AB_Y;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                if (r_step == MS_WHOLE_X) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_AREA;
            end
            ST_AREA: begin
                o_cmd.area = 1'b1;
                n_state    = i_status.box_empty ? ST_IDLE : ST_SCAN;
            end
            ST_SCAN: begin
                o_cmd.pixel = 1'b1;
                if (i_status.row_end) begin
                    n_state = ST_ROW;
                end
            end
            ST_ROW: begin
                if (i_status.out_free) begin
                    o_cmd.row_out = 1'b1;
                    n_state       = i_status.last_row ? ST_IDLE : ST_SCAN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/tfr_datapath.sv -----
// Datapath of the triangle fill rasterizer: bounding box, edge set-up, pixel test and row output.
`default_nettype none

module tfr_datapath
    import tfr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  t_cmd              i_cmd,
    output t_status           o_status,
    input  wire  [XW-1:0]     i_ax,
    input  wire  [YW-1:0]     i_ay,
    input  wire  [XW-1:0]     i_bx,
    input  wire  [YW-1:0]     i_by,
    input  wire  [XW-1:0]     i_cx,
    input  wire  [YW-1:0]     i_cy,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    output logic [YW-1:0]     o_row,
    output logic [MASK_W-1:0] o_mask,
    output logic              o_last
);

    localparam logic [XW-1:0] X_LAST = XW'(SCREEN_WIDTH - 1);
    localparam logic [YW-1:0] Y_LAST = YW'(SCREEN_HEIGHT - 1);

    logic [XW-1:0] r_ax, r_bx, r_cx;
    logic [YW-1:0] r_ay, r_by, r_cy;
    logic [XW-1:0] r_x0, r_x1, r_x;
    logic [YW-1:0] r_y0, r_y1, r_y;

    logic signed [DIFF_W-1:0] r_stepx [3];
    logic signed [DIFF_W-1:0] r_stepy [3];
    logic signed [EDGE_W-1:0] r_acc   [4];
    logic signed [EDGE_W-1:0] r_erow  [3];
    logic signed [EDGE_W-1:0] r_e     [3];
    logic        [EDGE_W-1:0] r_whole;

    logic signed [EDGE_W-1:0] r_prod;
    logic                     r_prod_vld;
    logic                     r_prod_neg;
    logic [1:0]               r_prod_idx;

    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid;
    logic [YW-1:0]     r_out_row;
    logic [MASK_W-1:0] r_out_mask;
    logic              r_out_last;

    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic                     mul_neg;
    logic [1:0]               mul_idx;
    logic [XW-1:0]            xmin_ab, xmax_ab, xmin, xmax;
    logic [YW-1:0]            ymin_ab, ymax_ab, ymin, ymax;
    logic [EDGE_W-1:0]        abs_e [3];
    logic [SUM_W-1:0]         area_sum;
    logic                     covered;
    logic                     row_end;

    function automatic logic signed [DIFF_W-1:0] dx(input logic [XW-1:0] p, input logic [XW-1:0] q);
        dx = $signed({1'b0, p}) - $signed({1'b0, q});
    endfunction

    function automatic logic signed [DIFF_W-1:0] dy(input logic [YW-1:0] p, input logic [YW-1:0] q);
        dy = $signed({2'b00, p}) - $signed({2'b00, q});
    endfunction

    function automatic logic signed [EDGE_W-1:0] sext(input logic signed [DIFF_W-1:0] v);
        sext = {{(EDGE_W-DIFF_W){v[DIFF_W-1]}}, v};
    endfunction

    function automatic logic [EDGE_W-1:0] mag(input logic signed [EDGE_W-1:0] v);
        mag = v[EDGE_W-1] ? EDGE_W'(-v) : EDGE_W'(v);
    endfunction

    always_comb begin
        xmin_ab = (r_ax < r_bx) ? r_ax : r_bx;
        xmax_ab = (r_ax > r_bx) ? r_ax : r_bx;
        xmin    = (xmin_ab < r_cx) ? xmin_ab : r_cx;
        xmax    = (xmax_ab > r_cx) ? xmax_ab : r_cx;
        ymin_ab = (r_ay < r_by) ? r_ay : r_by;
        ymax_ab = (r_ay > r_by) ? r_ay : r_by;
        ymin    = (ymin_ab < r_cy) ? ymin_ab : r_cy;
        ymax    = (ymax_ab > r_cy) ? ymax_ab : r_cy;
    end

    // Each edge value is (x2-x1)*(y-y1) - (y2-y1)*(x-x1) at the box corner.
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_idx = 2'd0;
        case (i_cmd.mul_step)
            MS_AB_Y: begin
                mul_a = dx(r_bx, r_ax); mul_b = dy(r_y0, r_ay); mul_idx = 2'd0;
            end
            MS_AB_X: begin
                mul_a = dy(r_by, r_ay); mul_b = dx(r_x0, r_ax); mul_idx = 2'd0; mul_neg = 1'b1;
            end
            MS_BC_Y: begin
                mul_a = dx(r_cx, r_bx); mul_b = dy(r_y0, r_by); mul_idx = 2'd1;
            end
            MS_BC_X: begin
                mul_a = dy(r_cy, r_by); mul_b = dx(r_x0, r_bx); mul_idx = 2'd1; mul_neg = 1'b1;
            end
            MS_CA_Y: begin
                mul_a = dx(r_ax, r_cx); mul_b = dy(r_y0, r_cy); mul_idx = 2'd2;
            end
            MS_CA_X: begin
                mul_a = dy(r_ay, r_cy); mul_b = dx(r_x0, r_cx); mul_idx = 2'd2; mul_neg = 1'b1;
            end
            MS_WHOLE_Y: begin
                mul_a = dx(r_bx, r_ax); mul_b = dy(r_cy, r_ay); mul_idx = 2'd3;
            end
            MS_WHOLE_X: begin
                mul_a = dy(r_by, r_ay); mul_b = dx(r_cx, r_ax); mul_idx = 2'd3; mul_neg = 1'b1;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            abs_e[i] = mag(r_e[i]);
        end
        area_sum = SUM_W'(abs_e[0]) + SUM_W'(abs_e[1]) + SUM_W'(abs_e[2]);
        covered  = (area_sum <= SUM_W'(r_whole)) && (r_x <= r_x1);
        row_end  = (r_x >= r_x1);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ax <= i_ax; r_ay <= i_ay;
            r_bx <= i_bx; r_by <= i_by;
            r_cx <= i_cx; r_cy <= i_cy;
        end
        if (i_cmd.box) begin
            r_x0 <= xmin;
            r_x1 <= (xmax > X_LAST) ? X_LAST : xmax;
            r_y0 <= ymin;
            r_y1 <= (ymax > Y_LAST) ? Y_LAST : ymax;
            r_stepx[0] <= dy(r_ay, r_by);
            r_stepx[1] <= dy(r_by, r_cy);
            r_stepx[2] <= dy(r_cy, r_ay);
            r_stepy[0] <= dx(r_bx, r_ax);
            r_stepy[1] <= dx(r_cx, r_bx);
            r_stepy[2] <= dx(r_ax, r_cx);
            for (int i = 0; i < 4; i++) begin
                r_acc[i] <= '0;
            end
        end
        if (i_cmd.mul) begin
            r_prod     <= EDGE_W'(mul_a * mul_b);
            r_prod_neg <= mul_neg;
            r_prod_idx <= mul_idx;
        end
        if (r_prod_vld) begin
            r_acc[r_prod_idx] <= r_prod_neg ? r_acc[r_prod_idx] - r_prod
                                            : r_acc[r_prod_idx] + r_prod;
        end
        if (i_cmd.area) begin
            r_whole <= mag(r_acc[3]);
            r_x     <= r_x0;
            r_y     <= r_y0;
            r_mask  <= '0;
            for (int i = 0; i < 3; i++) begin
                r_e[i]    <= r_acc[i];
                r_erow[i] <= r_acc[i];
            end
        end
        if (i_cmd.pixel) begin
            if (covered) begin
                r_mask[r_x] <= 1'b1;
            end
            if (!row_end) begin
                r_x <= r_x + 1'b1;
                for (int i = 0; i < 3; i++) begin
                    r_e[i] <= r_e[i] + sext(r_stepx[i]);
                end
            end
        end
        if (i_cmd.row_out) begin
            r_out_row  <= r_y;
            r_out_mask <= r_mask;
            r_out_last <= (r_y == r_y1);
            r_mask     <= '0;
            r_x        <= r_x0;
            r_y        <= r_y + 1'b1;
            for (int i = 0; i < 3; i++) begin
                r_erow[i] <= r_erow[i] + sext(r_stepy[i]);
                r_e[i]    <= r_erow[i] + sext(r_stepy[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_prod_vld <= i_cmd.mul;
            if (i_cmd.row_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.box_empty = (r_y0 > r_y1);
        o_status.row_end   = row_end;
        o_status.last_row  = (r_y == r_y1);
        o_status.out_free  = !r_out_valid || i_out_ready;
        o_out_valid        = r_out_valid;
        o_row              = r_out_row;
        o_mask             = r_out_mask;
        o_last             = r_out_last;
    end

endmodule

`default_nettype wire

// ----- sv/triangle_fill_rasterizer.sv -----
// Top level of the triangle fill rasterizer: one vertex triple in, one pixel-mask word per box row out.
//
//  channel   direction  tdata fields (lowest bit up)                      tuser  tlast
//  s_axis    in         ax[6:0] ay[12:7] bx[19:13] by[25:20] cx[32:26]    -      -
//                       cy[38:33], zero pad to 40 bits
//  m_axis    out        row[5:0] mask_low[69:6] mask_high[133:70],        -      last
//                       zero pad to 136 bits
//
// A triangle is first set up (bounding box, then eight products through one shared 8x8 multiplier),
// then scanned over the clipped box at one pixel test per cycle, with a row hand-off step after
// each row that can stall on the output register.
// A new triangle is accepted only once the last row has been handed to the output register, or its box is empty.
// The output register holds one row; the scan stalls at the end of a row while it is full and not being read.
// Reset is synchronous and active low, and clears the sequencer, the product valid flag and the output valid flag.
`default_nettype none

module triangle_fill_rasterizer
    import tfr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]  i_s_axis_tdata,  // ax, ay, bx, by, cx, cy
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,  // row, mask_low, mask_high
    output logic                   o_m_axis_tlast
);

    t_cmd              cmd;
    t_status           status;
    logic [YW-1:0]     out_row;
    logic [MASK_W-1:0] out_mask;

    tfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tfr_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_ax        (i_s_axis_tdata[6:0]),
        .i_ay        (i_s_axis_tdata[12:7]),
        .i_bx        (i_s_axis_tdata[19:13]),
        .i_by        (i_s_axis_tdata[25:20]),
        .i_cx        (i_s_axis_tdata[32:26]),
        .i_cy        (i_s_axis_tdata[38:33]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_row       (out_row),
        .o_mask      (out_mask),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {2'b00, out_mask, out_row};

endmodule

`default_nettype wire
